// File: rtl/core/swmc_pkg.sv
// Shared types and constants for the sliding-window median cost block.
`default_nettype none
package swmc_pkg;

	localparam int CFG_W  = 9;
	localparam int COST_W = 40;

	typedef struct packed {
		logic clear;
		logic remove;
		logic insert;
	} cell_op_t;

endpackage
`default_nettype wire

// File: rtl/core/sliding_window_median_cost_top.sv
// Top level of the sliding-window median cost block: sequencer, delay line and half sums.
// Each accepted request makes one removal pass and one insertion pass through the row of
// sorted cells; once the window is full, the result is registered onto the output after
// the insertion pass. A new request can be accepted during the insertion pass.
// Reset clears the window, the fill count and both half sums, and sets the window size to 1.
// The delay line holds no reset value; a value read from it is used only at written entries.
`default_nettype none
module sliding_window_median_cost_top #(
	parameter int MAX_WINDOW  = 256,
	parameter int SAMPLE_BITS = 32
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               sample_valid,
	output logic                              sample_ready,
	input  wire signed [31:0]                 sample,
	input  wire                               start_new,
	output logic                              cost_valid,
	input  wire                               cost_ready,
	output logic [swmc_pkg::COST_W-1:0]       window_cost,
	input  wire                               cfg_valid,
	output logic                              cfg_ready,
	input  wire [swmc_pkg::CFG_W-1:0]         window_size
);
	import swmc_pkg::*;

	localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
	localparam int ADDR_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int SUM_W  = SAMPLE_BITS + CNT_W + 1;
	localparam int EXT_W  = SUM_W - SAMPLE_BITS;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REMOVE,
		ST_INSERT
	} state_t;

	function automatic logic signed [SUM_W-1:0] sext(input logic signed [SAMPLE_BITS-1:0] v);
		return {{EXT_W{v[SAMPLE_BITS-1]}}, v};
	endfunction

	state_t                        state_q;
	logic [CNT_W-1:0]              k_q;
	logic [CNT_W-1:0]              half_q;
	logic [CNT_W-1:0]              fill_q;
	logic [ADDR_W-1:0]             wp_q;
	logic signed [SUM_W-1:0]       lsum_q;
	logic signed [SUM_W-1:0]       usum_q;
	logic                          pend_q;
	logic                          cost_valid_q;
	logic [COST_W-1:0]             cost_q;
	logic signed [SAMPLE_BITS-1:0] x_q;
	logic                          start_q;
	logic signed [SAMPLE_BITS-1:0] d_q;
	logic signed [SAMPLE_BITS-1:0] dly_mem [MAX_WINDOW];

	logic                          acc;
	logic                          cfg_acc;
	logic                          emit_go;
	logic                          remove_go;
	logic                          full;
	logic [CNT_W-1:0]              k_eff;
	logic [CNT_W:0]                k_inc;
	logic [ADDR_W-1:0]             wp_eff;
	logic [CNT_W:0]                wp_inc;
	logic [ADDR_W-1:0]             wp_nxt;
	cell_op_t                      op;
	logic signed [SAMPLE_BITS-1:0] hi_val;
	logic                          hi_vld;
	logic signed [SAMPLE_BITS-1:0] lo_val;
	logic                          lo_vld;
	logic signed [SUM_W-1:0]       hi_term;
	logic signed [SUM_W-1:0]       lo_term;
	logic                          rm_low;
	logic                          ins_low;
	logic signed [SUM_W-1:0]       cost_sum;

	assign sample_ready = (state_q == ST_IDLE) || (state_q == ST_INSERT);
	assign cfg_ready    = (state_q == ST_IDLE) && !pend_q;
	assign acc          = sample_valid && sample_ready;
	assign cfg_acc      = cfg_valid && cfg_ready;
	assign emit_go      = pend_q && (!cost_valid_q || cost_ready) && (state_q != ST_INSERT);
	assign remove_go    = (state_q == ST_REMOVE) && (!pend_q || emit_go);
	assign full         = (fill_q == k_q);
	assign cost_valid   = cost_valid_q;
	assign window_cost  = cost_q;

	always_comb begin
		if (window_size == '0) begin
			k_eff = CNT_W'(1);
		end else if (int'(window_size) > MAX_WINDOW) begin
			k_eff = CNT_W'(MAX_WINDOW);
		end else begin
			k_eff = CNT_W'(window_size);
		end
	end
	assign k_inc = {1'b0, k_eff} + 1'b1;

	assign wp_eff = start_q ? '0 : wp_q;
	assign wp_inc = (CNT_W + 1)'(wp_eff) + 1'b1;
	assign wp_nxt = (wp_inc >= {1'b0, k_q}) ? '0 : ADDR_W'(wp_inc);

	always_comb begin
		op.clear  = cfg_acc || (remove_go && start_q);
		op.remove = remove_go && !start_q && full;
		op.insert = (state_q == ST_INSERT);
	end

	swmc_chain #(
		.MAX_WINDOW (MAX_WINDOW),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (op),
		.del_val(d_q),
		.ins_val(x_q),
		.half   (half_q),
		.hi_val (hi_val),
		.hi_vld (hi_vld),
		.lo_val (lo_val),
		.lo_vld (lo_vld)
	);

	assign hi_term  = hi_vld ? sext(hi_val) : '0;
	assign lo_term  = lo_vld ? sext(lo_val) : '0;
	assign rm_low   = !hi_vld || (hi_val > d_q);
	assign ins_low  = !lo_vld || (lo_val > x_q);
	assign cost_sum = usum_q - lsum_q + (k_q[0] ? sext(lo_val) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			k_q          <= CNT_W'(1);
			half_q       <= CNT_W'(1);
			fill_q       <= '0;
			wp_q         <= '0;
			lsum_q       <= '0;
			usum_q       <= '0;
			pend_q       <= 1'b0;
			cost_valid_q <= 1'b0;
			cost_q       <= '0;
		end else begin
			if (emit_go) begin
				cost_q       <= COST_W'($unsigned(cost_sum));
				cost_valid_q <= 1'b1;
				pend_q       <= 1'b0;
			end else if (cost_ready) begin
				cost_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cfg_acc) begin
						k_q    <= k_eff;
						half_q <= CNT_W'(k_inc >> 1);
						fill_q <= '0;
						wp_q   <= '0;
						lsum_q <= '0;
						usum_q <= '0;
					end
					if (acc) begin
						state_q <= ST_REMOVE;
					end
				end
				ST_REMOVE: begin
					if (remove_go) begin
						state_q <= ST_INSERT;
						wp_q    <= wp_nxt;
						if (start_q) begin
							fill_q <= '0;
							lsum_q <= '0;
							usum_q <= '0;
						end else if (full) begin
							fill_q <= k_q - 1'b1;
							if (rm_low) begin
								lsum_q <= lsum_q - sext(d_q) + hi_term;
								usum_q <= usum_q - hi_term;
							end else begin
								usum_q <= usum_q - sext(d_q);
							end
						end
					end
				end
				ST_INSERT: begin
					fill_q <= fill_q + 1'b1;
					pend_q <= ((fill_q + 1'b1) == k_q);
					if (ins_low) begin
						lsum_q <= lsum_q + sext(x_q) - lo_term;
						usum_q <= usum_q + lo_term;
					end else begin
						usum_q <= usum_q + sext(x_q);
					end
					state_q <= acc ? ST_REMOVE : ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			x_q     <= sample[SAMPLE_BITS-1:0];
			start_q <= start_new;
			d_q     <= dly_mem[wp_q];
		end
	end

	always_ff @(posedge clk) begin
		if (remove_go) begin
			dly_mem[wp_eff] <= x_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= k_q)
		else $error("fill count exceeds window size");

	a_no_pend_in_insert: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |-> !pend_q)
		else $error("insertion pass started with an unsent result");

	a_fill_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INSERT) |=> (fill_q == $past(fill_q) + 1'b1))
		else $error("insertion pass did not grow the window by one");

	a_emit_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(cost_valid_q) |-> $past(pend_q))
		else $error("result offered without a completed window");

endmodule
`default_nettype wire

// File: rtl/core/swmc_cell.sv
// One cell of the sorted row: holds one sample and its valid bit.
`default_nettype none
module swmc_cell #(
	parameter int SAMPLE_BITS = 32
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  swmc_pkg::cell_op_t           op,
	input  wire signed [SAMPLE_BITS-1:0] del_val,
	input  wire signed [SAMPLE_BITS-1:0] ins_val,
	input  wire signed [SAMPLE_BITS-1:0] below_val,
	input  wire                          below_vld,
	input  wire                          below_gt,
	input  wire signed [SAMPLE_BITS-1:0] above_val,
	input  wire                          above_vld,
	output logic signed [SAMPLE_BITS-1:0] val,
	output logic                         vld,
	output logic                         gt
);
	import swmc_pkg::*;

	logic signed [SAMPLE_BITS-1:0] val_q;
	logic                          vld_q;
	logic                          rm_here;

	// A cell shifts down when it sits at or above the last entry equal to the removed value.
	assign rm_here = vld_q && ((val_q > del_val) ||
		((val_q == del_val) && (!above_vld || (above_val != del_val))));
	assign gt  = vld_q && (val_q > ins_val);
	assign val = val_q;
	assign vld = vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else priority if (op.clear) begin
			vld_q <= 1'b0;
		end else if (op.remove && rm_here) begin
			vld_q <= above_vld;
		end else if (op.insert && (below_gt || ((gt || !vld_q) && below_vld))) begin
			vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		priority if (op.clear) begin
			val_q <= val_q;
		end else if (op.remove && rm_here) begin
			val_q <= above_val;
		end else if (op.insert && below_gt) begin
			val_q <= below_val;
		end else if (op.insert && (gt || !vld_q) && below_vld) begin
			val_q <= ins_val;
		end
	end

endmodule
`default_nettype wire

// File: rtl/core/swmc_chain.sv
// Row of sorted cells with the two boundary taps around the lower median.
`default_nettype none
module swmc_chain #(
	parameter int MAX_WINDOW  = 256,
	parameter int SAMPLE_BITS = 32,
	localparam int CNT_W      = $clog2(MAX_WINDOW + 1)
) (
	input  wire                           clk,
	input  wire                           arst_n,
	input  swmc_pkg::cell_op_t            op,
	input  wire signed [SAMPLE_BITS-1:0]  del_val,
	input  wire signed [SAMPLE_BITS-1:0]  ins_val,
	input  wire [CNT_W-1:0]               half,
	output logic signed [SAMPLE_BITS-1:0] hi_val,
	output logic                          hi_vld,
	output logic signed [SAMPLE_BITS-1:0] lo_val,
	output logic                          lo_vld
);
	import swmc_pkg::*;

	logic signed [SAMPLE_BITS-1:0] cval [MAX_WINDOW];
	logic [MAX_WINDOW-1:0]         cvld;
	logic [MAX_WINDOW-1:0]         cgt;
	logic [MAX_WINDOW-1:0]         hit_hi;
	logic [MAX_WINDOW-1:0]         hit_lo;

	for (genvar j = 0; j < MAX_WINDOW; j++) begin : g_cell
		logic signed [SAMPLE_BITS-1:0] b_val;
		logic                          b_vld;
		logic                          b_gt;
		logic signed [SAMPLE_BITS-1:0] a_val;
		logic                          a_vld;

		if (j == 0) begin : g_first
			assign b_val = '0;
			assign b_vld = 1'b1;
			assign b_gt  = 1'b0;
		end else begin : g_mid
			assign b_val = cval[j-1];
			assign b_vld = cvld[j-1];
			assign b_gt  = cgt[j-1];
		end

		if (j == MAX_WINDOW - 1) begin : g_last
			assign a_val = '0;
			assign a_vld = 1'b0;
		end else begin : g_inner
			assign a_val = cval[j+1];
			assign a_vld = cvld[j+1];
		end

		assign hit_hi[j] = (CNT_W'(j) == half);
		assign hit_lo[j] = (CNT_W'(j + 1) == half);

		swmc_cell #(
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.op       (op),
			.del_val  (del_val),
			.ins_val  (ins_val),
			.below_val(b_val),
			.below_vld(b_vld),
			.below_gt (b_gt),
			.above_val(a_val),
			.above_vld(a_vld),
			.val      (cval[j]),
			.vld      (cvld[j]),
			.gt       (cgt[j])
		);
	end

	always_comb begin
		hi_val = '0;
		hi_vld = 1'b0;
		lo_val = '0;
		lo_vld = 1'b0;
		for (int j = 0; j < MAX_WINDOW; j++) begin
			hi_val = hi_val | ({SAMPLE_BITS{hit_hi[j]}} & cval[j]);
			hi_vld = hi_vld | (hit_hi[j] & cvld[j]);
			lo_val = lo_val | ({SAMPLE_BITS{hit_lo[j]}} & cval[j]);
			lo_vld = lo_vld | (hit_lo[j] & cvld[j]);
		end
	end

endmodule
`default_nettype wire
